// ===== rtl/core/c_token_classifier_assert.svh =====
// Assertion macros for the token classifier checker.
`ifndef C_TOKEN_CLASSIFIER_ASSERT_SVH
`define C_TOKEN_CLASSIFIER_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset
`define CTC_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("token classifier check failed");

// Concurrent assertion on the block clock and reset
`define CTC_ASSERT(lbl, prop) `CTC_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== rtl/core/ctc_pkg.sv =====
`default_nettype none

package ctc_pkg;

    // Word buffer depth and derived widths
    localparam int MAX_WORD = 16;
    localparam int CNT_W    = $clog2(MAX_WORD + 1);
    localparam int IDX_W    = $clog2(MAX_WORD);
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 8;
    localparam int TDATA_W  = 16;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_KEYWORD    = 3'd0,
        KIND_PREPROC    = 3'd1,
        KIND_HEADER     = 3'd2,
        KIND_IDENT      = 3'd3,
        KIND_PUNCT      = 3'd4,
        KIND_OPERATOR   = 3'd5
    } t_kind;

    typedef logic [7:0] t_letters [MAX_WORD];

    // Pending word result, as seen at a flush
    typedef struct packed {
        logic               vld;
        t_kind              kind;
        logic [LEN_W-1:0]   len;
        logic               trunc;
    } t_word_res;

    // All results of one item
    typedef struct packed {
        t_word_res          word;
        logic               pun_vld;
        logic               op_vld;
        logic [SYM_W-1:0]   sym;
    } t_bundle;

    // Constant word lists, right-aligned text of up to eight letters
    localparam int KW_NUM  = 27;
    localparam int PP_NUM  = 2;
    localparam int HDR_NUM = 5;

    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "long", "short", "typedef",
        "switch", "unsigned", "void", "static", "struct", "sizeof",
        "volatile", "enum", "const", "union", "extern", "bool"
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd5, 4'd8, 4'd3, 4'd6,
        4'd5, 4'd6, 4'd4, 4'd4, 4'd4, 4'd5, 4'd7,
        4'd6, 4'd8, 4'd4, 4'd6, 4'd6, 4'd6,
        4'd8, 4'd4, 4'd5, 4'd5, 4'd6, 4'd4
    };
    localparam logic [63:0] PP_TEXT [PP_NUM] = '{"include", "define"};
    localparam logic [3:0]  PP_LEN  [PP_NUM] = '{4'd7, 4'd6};
    localparam logic [63:0] HDR_TEXT [HDR_NUM] = '{
        "stdio", "conio", "math", "stdlib", "string"
    };
    localparam logic [3:0]  HDR_LEN [HDR_NUM] = '{4'd5, 4'd5, 4'd4, 4'd6, 4'd6};

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "|" ||
               c == "&" || c == ">" || c == "<" || c == "=";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return is_oper(c) || c == "#" || c == "(" || c == ")" || c == "[" ||
               c == "]" || c == "{" || c == "}" || c == "," || c == ";" ||
               c == 8'h22;
    endfunction

    // Class a stored word by exact match against the lists
    function automatic t_kind class_word(input t_letters l,
                                         input logic [CNT_W-1:0] n,
                                         input logic ovf);
        logic [63:0] w;
        logic        kw_hit;
        logic        pp_hit;
        logic        hdr_hit;
        t_kind       k;
        w       = '0;
        kw_hit  = 1'b0;
        pp_hit  = 1'b0;
        hdr_hit = 1'b0;
        // pack the first letters, first one highest
        for (int i = 0; i < 8; i++) begin
            if (CNT_W'(i) < n) begin
                w = {w[55:0], l[i]};
            end
        end
        for (int j = 0; j < KW_NUM; j++) begin
            kw_hit |= (n == CNT_W'(KW_LEN[j])) && (w == KW_TEXT[j]);
        end
        for (int j = 0; j < PP_NUM; j++) begin
            pp_hit |= (n == CNT_W'(PP_LEN[j])) && (w == PP_TEXT[j]);
        end
        for (int j = 0; j < HDR_NUM; j++) begin
            hdr_hit |= (n == CNT_W'(HDR_LEN[j])) && (w == HDR_TEXT[j]);
        end
        if (ovf)          k = KIND_IDENT;
        else if (kw_hit)  k = KIND_KEYWORD;
        else if (pp_hit)  k = KIND_PREPROC;
        else if (hdr_hit) k = KIND_HEADER;
        else              k = KIND_IDENT;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ctc_word_unit.sv =====
`default_nettype none

module ctc_word_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    input  wire logic              i_end,
    output ctc_pkg::t_word_res     o_word
);
    import ctc_pkg::*;

    t_letters           r_letters;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [CNT_W-1:0]   n_count;
    logic               n_ovf;
    logic               letter;
    logic               flush;
    logic               store;

    assign letter = !i_end && is_letter(i_byte);
    assign flush  = i_end || !letter;
    assign store  = i_step && letter && (r_count < CNT_W'(MAX_WORD));

    // Report the pending word when this item ends it
    always_comb begin
        o_word.vld   = flush && (r_count != '0);
        o_word.kind  = class_word(r_letters, r_count, r_ovf);
        o_word.len   = LEN_W'(r_count);
        o_word.trunc = r_ovf;
    end

    // Advance letter count and overflow flag
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_step) begin
            if (flush) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (r_count < CNT_W'(MAX_WORD)) begin
                n_count = CNT_W'(r_count + 1'b1);
            end else begin
                n_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Store the letter at the next free place
    always_ff @(posedge i_clk) begin
        if (store) begin
            r_letters[r_count[IDX_W-1:0]] <= i_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ctc_out_seq.sv =====
`default_nettype none

module ctc_out_seq (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  ctc_pkg::t_bundle           i_bundle,
    output logic                       o_can_load,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: symbol [7:0], word_length [12:8], word_truncated [13], zero [15:14]
    output logic [ctc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // tuser: token_kind [2:0]
    output logic [2:0]                 o_m_axis_tuser,
    output logic                       o_m_axis_tlast
);
    import ctc_pkg::*;

    logic               r_word_vld;
    logic               r_pun_vld;
    logic               r_op_vld;
    t_kind              r_kind;
    logic [LEN_W-1:0]   r_len;
    logic               r_trunc;
    logic [SYM_W-1:0]   r_sym;
    logic               n_word_vld;
    logic               n_pun_vld;
    logic               n_op_vld;
    logic               sel_word;
    logic               sel_pun;
    logic               fire;
    t_kind              kind;
    logic [SYM_W-1:0]   sym;
    logic [LEN_W-1:0]   len;
    logic               trunc;

    // Pick the first pending result: word, then punctuator, then operator
    assign sel_word = r_word_vld;
    assign sel_pun  = !r_word_vld && r_pun_vld;
    assign o_m_axis_tvalid = r_word_vld || r_pun_vld || r_op_vld;
    assign fire = o_m_axis_tvalid && i_m_axis_tready;

    always_comb begin
        if (sel_word) begin
            kind           = r_kind;
            sym            = '0;
            len            = r_len;
            trunc          = r_trunc;
            o_m_axis_tlast = !(r_pun_vld || r_op_vld);
        end else if (sel_pun) begin
            kind           = KIND_PUNCT;
            sym            = r_sym;
            len            = '0;
            trunc          = 1'b0;
            o_m_axis_tlast = !r_op_vld;
        end else begin
            kind           = KIND_OPERATOR;
            sym            = r_sym;
            len            = '0;
            trunc          = 1'b0;
            o_m_axis_tlast = 1'b1;
        end
    end

    assign o_m_axis_tdata = {2'b00, trunc, len, sym};
    assign o_m_axis_tuser = kind;

    // Drop the result just taken
    assign n_word_vld = r_word_vld && !(fire && sel_word);
    assign n_pun_vld  = r_pun_vld && !(fire && sel_pun);
    assign n_op_vld   = r_op_vld && !(fire && !r_word_vld && !r_pun_vld);
    assign o_can_load = !(n_word_vld || n_pun_vld || n_op_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= 1'b0;
            r_pun_vld  <= 1'b0;
            r_op_vld   <= 1'b0;
        end else if (i_load) begin
            r_word_vld <= i_bundle.word.vld;
            r_pun_vld  <= i_bundle.pun_vld;
            r_op_vld   <= i_bundle.op_vld;
        end else begin
            r_word_vld <= n_word_vld;
            r_pun_vld  <= n_pun_vld;
            r_op_vld   <= n_op_vld;
        end
    end

    // Hold the payload of the item's results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind  <= i_bundle.word.kind;
            r_len   <= i_bundle.word.len;
            r_trunc <= i_bundle.word.trunc;
            r_sym   <= i_bundle.sym;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/c_token_classifier.sv =====
// C token classifier.
// Slave channel: one source byte per item in tdata[7:0]; tlast marks end of
// text and flushes the pending word (tdata is then ignored).
// Master channel: one token per item. tuser carries the kind (keyword,
// preprocessor word, header name, identifier, punctuator, operator),
// tdata the symbol, word length and truncation flag; tlast marks the last
// token caused by one input item.
// Letters are collected into a 16-letter word buffer; a non-letter or the
// end mark ends the word, which is matched in parallel against the constant
// word lists. Longer words are reported as truncated identifiers.
// The first token of an item passes the input register, then the result
// register, before it shows on the master channel.
// Throughput: one item per cycle while each item gives at most one token and
// the receiver is ready; an item giving several tokens holds the result
// register until all of them have left by the single output port.
// Reset clears the pending word and all pending tokens. When the receiver
// stalls, the current token holds and the block takes one more item into
// its input register before it stops accepting.
`default_nettype none

module c_token_classifier (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // tdata: text_byte [7:0]
    input  wire logic [7:0]             i_s_axis_tdata,
    // tlast: end_of_text
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // tdata: symbol [7:0], word_length [12:8], word_truncated [13], zero [15:14]
    output logic [ctc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    // tuser: token_kind [2:0]
    output logic [2:0]                  o_m_axis_tuser,
    output logic                        o_m_axis_tlast
);
    import ctc_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       step;
    logic       can_load;
    t_word_res  word;
    t_bundle    bundle;

    // Process the held item once the result register can take it
    assign step = r_in_vld && can_load;
    assign o_s_axis_tready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    ctc_word_unit u_word (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_word  (word)
    );

    // Gather the item's results
    always_comb begin
        bundle.word    = word;
        bundle.pun_vld = !r_in_end && is_punct(r_in_byte);
        bundle.op_vld  = !r_in_end && is_oper(r_in_byte);
        bundle.sym     = r_in_byte;
    end

    ctc_out_seq u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (step),
        .i_bundle        (bundle),
        .o_can_load      (can_load),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ctc_checker.sv =====
`default_nettype none

`include "c_token_classifier_assert.svh"

module ctc_checker (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic                   o_s_axis_tready,
    input  wire logic [7:0]             i_s_axis_tdata,
    input  wire logic                   i_s_axis_tlast,
    input  wire logic                   o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [ctc_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input  wire logic [2:0]             o_m_axis_tuser,
    input  wire logic                   o_m_axis_tlast
);
    import ctc_pkg::*;

    logic is_word;
    logic unused_in;

    assign is_word = o_m_axis_tuser == KIND_KEYWORD || o_m_axis_tuser == KIND_PREPROC ||
                     o_m_axis_tuser == KIND_HEADER || o_m_axis_tuser == KIND_IDENT;
    assign unused_in = i_s_axis_tvalid ^ o_s_axis_tready ^ (^i_s_axis_tdata) ^ i_s_axis_tlast;

    // Stalled token holds
    `CTC_ASSERT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // Word tokens carry no symbol and a nonzero length
    `CTC_ASSERT(a_word_fields, o_m_axis_tvalid && is_word |-> o_m_axis_tdata[7:0] == 8'd0 && o_m_axis_tdata[12:8] != 5'd0 || unused_in && !unused_in)

    // A punctuator not closing its run is followed by the operator form
    `CTC_ASSERT(a_pun_then_op, o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser == KIND_PUNCT && !o_m_axis_tlast |=> o_m_axis_tvalid && o_m_axis_tuser == KIND_OPERATOR && o_m_axis_tdata[7:0] == $past(o_m_axis_tdata[7:0]))

    // A truncated word is a full-length identifier
    `CTC_ASSERT(a_trunc_ident, o_m_axis_tvalid && o_m_axis_tdata[13] |-> o_m_axis_tuser == KIND_IDENT && o_m_axis_tdata[12:8] == LEN_W'(MAX_WORD))

endmodule

bind c_token_classifier ctc_checker u_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    import ctc_pkg::*;

    localparam int ITEM_TARGET    = 430;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORT     = 10;

    // One token as it leaves the block
    typedef struct {
        t_kind      kind;
        logic [7:0] sym;
        logic [4:0] len;
        logic       trunc;
        logic       last;
    } token_t;

    // Directed row: letters of a word, then one closing item
    typedef struct {
        string      word;
        logic [7:0] tail;
        logic       tail_eot;
        bit         typed;
        int         typed_n;
        token_t     tok;
    } dir_row_t;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [7:0]           i_s_axis_tdata  = 8'h00;
    logic                 i_s_axis_tlast  = 1'b0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [TDATA_W-1:0]   o_m_axis_tdata;
    logic [2:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    c_token_classifier dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // Word lists and character sets
    string kw_words [27] = '{
        "if", "else", "while", "do", "break", "continue", "int", "double",
        "float", "return", "char", "case", "long", "short", "typedef",
        "switch", "unsigned", "void", "static", "struct", "sizeof",
        "volatile", "enum", "const", "union", "extern", "bool"
    };
    string pp_words  [2] = '{"include", "define"};
    string hdr_words [5] = '{"stdio", "conio", "math", "stdlib", "string"};
    string op_set    = "+-*/|&><=";
    string punct_set = "+-*/|&><=#()[]{},;\"";

    dir_row_t dir_rows [11] = '{
        '{"", 8'h00, 1'b1, 1'b1, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"", 8'h00, 1'b0, 1'b1, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"", 8'hFF, 1'b0, 1'b1, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"", "(",   1'b0, 1'b1, 1, '{KIND_PUNCT,   "(",   5'd0, 1'b0, 1'b1}},
        '{"", "+",   1'b0, 1'b0, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"if", 8'h00, 1'b1, 1'b1, 1, '{KIND_KEYWORD, 8'h00, 5'd2, 1'b0, 1'b1}},
        '{"math", ";", 1'b0, 1'b0, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"define", 8'hFF, 1'b1, 1'b1, 1, '{KIND_PREPROC, 8'h00, 5'd6, 1'b0, 1'b1}},
        '{"Za", 8'h7F, 1'b0, 1'b1, 1, '{KIND_IDENT, 8'h00, 5'd2, 1'b0, 1'b1}},
        '{"", "=",   1'b0, 1'b0, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}},
        '{"", 8'h80, 1'b0, 1'b1, 0, '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0}}
    };

    // Shadow of the pending word
    logic [7:0] word_buf [MAX_WORD];
    int         word_cnt = 0;
    bit         word_ovf = 1'b0;
    token_t     item_toks [$];
    token_t     tok_expected [$];

    // Side information for the item on the input bus
    bit         cur_typed   = 1'b0;
    int         cur_typed_n = 0;
    token_t     cur_tok;
    token_t     no_tok;
    bit         gaps_on     = 1'b1;

    int         items_sent  = 0;
    int         dir_items   = 0;
    int         toks_seen   = 0;
    int         trunc_seen  = 0;
    int         kind_seen [6];
    int         mismatches  = 0;
    int         idle_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit in_set(input logic [7:0] c, input string set);
        for (int i = 0; i < set.len(); i++) begin
            if (set[i] == c) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Emit the pending word, classed by exact match
    function automatic void end_word();
        token_t t;
        string  w;
        if (word_cnt == 0) return;
        w = "";
        for (int i = 0; i < word_cnt; i++) w = $sformatf("%s%c", w, word_buf[i]);
        t.kind = KIND_IDENT;
        if (!word_ovf) begin
            foreach (hdr_words[i]) if (hdr_words[i] == w) t.kind = KIND_HEADER;
            foreach (pp_words[i]) if (pp_words[i] == w) t.kind = KIND_PREPROC;
            foreach (kw_words[i]) if (kw_words[i] == w) t.kind = KIND_KEYWORD;
        end
        t.sym   = 8'h00;
        t.len   = 5'(word_cnt);
        t.trunc = word_ovf;
        t.last  = 1'b0;
        item_toks.push_back(t);
        word_cnt = 0;
        word_ovf = 1'b0;
    endfunction

    function automatic void sym_token(input t_kind k, input logic [7:0] c);
        token_t t;
        t.kind  = k;
        t.sym   = c;
        t.len   = 5'd0;
        t.trunc = 1'b0;
        t.last  = 1'b0;
        item_toks.push_back(t);
    endfunction

    // Work out the tokens that one input item causes
    function automatic void classify_item(input logic [7:0] c, input logic eot);
        item_toks.delete();
        if (eot) begin
            end_word();
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
            if (word_cnt < MAX_WORD) begin
                word_buf[word_cnt] = c;
                word_cnt++;
            end else begin
                word_ovf = 1'b1;
            end
        end else begin
            end_word();
            if (in_set(c, punct_set)) sym_token(KIND_PUNCT, c);
            if (in_set(c, op_set)) sym_token(KIND_OPERATOR, c);
        end
        if (item_toks.size() > 0) item_toks[item_toks.size()-1].last = 1'b1;
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("token mismatch: %s", msg);
    endfunction

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 1) return 8'("A") + 8'($urandom_range(0, 25));
        return 8'("a") + 8'($urandom_range(0, 25));
    endfunction

    // Monitor both sides, predict on input, check on output
    always @(posedge i_clk) begin : mon
        token_t want;
        bit     took_in;
        bit     took_out;
        took_in  = i_s_axis_tvalid && o_s_axis_tready;
        took_out = o_m_axis_tvalid && i_m_axis_tready;
        if (i_rst_n) begin
            if (took_in) begin
                classify_item(i_s_axis_tdata, i_s_axis_tlast);
                if (cur_typed) begin
                    if (cur_typed_n > 0) tok_expected.push_back(cur_tok);
                end else begin
                    foreach (item_toks[i]) tok_expected.push_back(item_toks[i]);
                end
            end
            if (took_out) begin
                if (tok_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected kind %0d tdata %h last %b",
                                              o_m_axis_tuser, o_m_axis_tdata,
                                              o_m_axis_tlast));
                end else begin
                    want = tok_expected.pop_front();
                    toks_seen++;
                    if (want.kind <= KIND_OPERATOR) kind_seen[want.kind]++;
                    if (want.trunc) trunc_seen++;
                    if (o_m_axis_tuser !== want.kind || o_m_axis_tdata[7:0] !== want.sym ||
                        o_m_axis_tdata[12:8] !== want.len ||
                        o_m_axis_tdata[13] !== want.trunc ||
                        o_m_axis_tdata[15:14] !== 2'b00 ||
                        o_m_axis_tlast !== want.last) begin
                        report_mismatch($sformatf(
                            "exp kind %0d sym %h len %0d trunc %b last %b, got kind %0d sym %h len %0d trunc %b pad %b last %b",
                            want.kind, want.sym, want.len, want.trunc, want.last,
                            o_m_axis_tuser, o_m_axis_tdata[7:0], o_m_axis_tdata[12:8],
                            o_m_axis_tdata[13], o_m_axis_tdata[15:14], o_m_axis_tlast));
                    end
                end
            end
            // Watchdog on a stalled interface
            if (took_in || took_out) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    // Receiver: bursts of ready with random stalls
    initial begin : sink
        int run;
        int gap;
        @(posedge i_rst_n);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (run) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b1;
            end
            gap = idle_len();
            repeat (gap) begin
                @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    // Offer one item, with an optional idle gap in front
    task automatic send_item(input logic [7:0] ch, input logic eot, input bit typed,
                             input int typed_n, input token_t tok);
        int gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tlast  <= eot;
        cur_typed   = typed;
        cur_typed_n = typed_n;
        cur_tok     = tok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // Close a word: symbol, blank, end mark or stray byte
    task automatic send_separator();
        int         sel;
        logic [7:0] ch;
        logic       eot;
        sel = $urandom_range(0, 99);
        eot = 1'b0;
        if (sel < 45) begin
            ch = punct_set[$urandom_range(0, punct_set.len() - 1)];
        end else if (sel < 60) begin
            ch = ($urandom_range(0, 1) == 1) ? 8'h20 : 8'h0A;
        end else if (sel < 75) begin
            ch  = 8'($urandom_range(0, 255));
            eot = 1'b1;
        end else if (sel < 90) begin
            ch = 8'($urandom_range(0, 64));
        end else begin
            ch = 8'($urandom_range(128, 255));
        end
        send_item(ch, eot, 1'b0, 0, no_tok);
    endtask

    // Drop valid and hold until every token has come out
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (tok_expected.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stim
        string w;
        int    sel;
        int    idx;
        int    len;
        bit    paused_mid;
        no_tok     = '{KIND_KEYWORD, 8'h00, 5'd0, 1'b0, 1'b0};
        cur_tok    = no_tok;
        paused_mid = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        foreach (word_buf[k]) word_buf[k] = 8'h00;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[r]) begin
            for (int i = 0; i < dir_rows[r].word.len(); i++) begin
                send_item(dir_rows[r].word[i], 1'b0, 1'b0, 0, no_tok);
            end
            send_item(dir_rows[r].tail, dir_rows[r].tail_eot, dir_rows[r].typed,
                      dir_rows[r].typed_n, dir_rows[r].tok);
        end
        dir_items = items_sent;
        hold_until_drained();

        // Random text: mostly real and near-miss words, some noise
        while (items_sent - dir_items < ITEM_TARGET) begin
            if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                idx = $urandom_range(0, 33);
                if (idx < 27) w = kw_words[idx];
                else if (idx < 29) w = pp_words[idx - 27];
                else w = hdr_words[idx - 29];
                case ($urandom_range(0, 9))
                    0: begin
                        idx = $urandom_range(0, w.len() - 1);
                        w[idx] = w[idx] ^ 8'h20;
                    end
                    1: w = w.substr(0, w.len() - 2);
                    2: begin
                        w = {w, "x"};
                        w[w.len() - 1] = rand_letter();
                    end
                    default: ;
                endcase
                for (int i = 0; i < w.len(); i++) send_item(w[i], 1'b0, 1'b0, 0, no_tok);
                send_separator();
            end else if (sel < 65) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(1, 8);
                repeat (len) send_item(rand_letter(), 1'b0, 1'b0, 0, no_tok);
                send_separator();
            end else if (sel < 80) begin
                send_separator();
            end else begin
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                          1'b0, 0, no_tok);
            end
            if (!paused_mid && items_sent - dir_items >= ITEM_TARGET / 2) begin
                hold_until_drained();
                paused_mid = 1'b1;
            end
        end

        // Flush and let the pipeline settle
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tok_expected.size() != 0) begin
            report_mismatch($sformatf("%0d tokens never arrived", tok_expected.size()));
        end

        $display("Run covered %0d input items (%0d directed), %0d tokens, %0d truncated words",
                 items_sent, dir_items, toks_seen, trunc_seen);
        $display("Tokens by kind: keyword %0d, preproc %0d, header %0d, ident %0d, punct %0d, operator %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
